FILE: src/l8h_pkg.sv
// Shared types, constants and the mix-row function for the 64-bit lookup8 byte-stream hash.
// No dependencies; every other file in src imports this package.
package l8h_pkg;

    localparam int unsigned LANE_W      = 64;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned BLOCK_BYTES = 24;
    localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned WORD_BYTES  = LANE_W / 8;
    localparam int unsigned MIX_ROWS    = 12;
    localparam int unsigned ROW_W       = $clog2(MIX_ROWS);

    localparam logic [LANE_W-1:0] GOLDEN64   = 64'h9E37_79B9_7F4A_7C13;
    localparam logic [LANE_W-1:0] SEED_RESET = 64'hABCD_EF00_1122_3344;

    typedef enum logic [1:0] {
        LANE_A,
        LANE_B,
        LANE_C
    } t_lane_sel;

    // Per row of the mix ladder: which lane is updated and by how far the other is shifted.
    localparam t_lane_sel MIX_LANE [MIX_ROWS] = '{
        LANE_A, LANE_B, LANE_C, LANE_A, LANE_B, LANE_C,
        LANE_A, LANE_B, LANE_C, LANE_A, LANE_B, LANE_C
    };
    localparam int unsigned MIX_SHIFT [MIX_ROWS] = '{
        43, 9, 8, 38, 23, 5, 35, 49, 11, 12, 18, 22
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [LANE_W-1:0] hash;
        logic [KEY_W-1:0]  key32;
    } t_out_item;

    typedef struct packed {
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
        logic [LANE_W-1:0] c;
    } t_lanes;

    // Control that travels with each entry of the mix pipeline.
    typedef struct packed {
        logic valid;
        logic fin;
    } t_mix_ctl;

    // One row of the subtract / xor-shift ladder. Right shifts for rows that update a or c,
    // left shifts for rows that update b.
    function automatic t_lanes mix_row(input t_lanes x, input logic [ROW_W-1:0] row);
        t_lanes y;
        y = x;
        case (MIX_LANE[row])
            LANE_A: begin
                y.a = x.a - x.b - x.c;
                y.a = y.a ^ (x.c >> MIX_SHIFT[row]);
            end
            LANE_B: begin
                y.b = x.b - x.c - x.a;
                y.b = y.b ^ (x.a << MIX_SHIFT[row]);
            end
            default: begin
                y.c = x.c - x.a - x.b;
                y.c = y.c ^ (x.b >> MIX_SHIFT[row]);
            end
        endcase
        return y;
    endfunction

endpackage

FILE: src/l8h_mix_pipe.sv
// Registered twelve-row mix ladder: an entry register followed by one register per row.
// Depends on l8h_pkg for the lane types and mix_row.
module l8h_mix_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  l8h_pkg::t_mix_ctl i_ctl,
    input  l8h_pkg::t_lanes   i_lanes,
    output l8h_pkg::t_mix_ctl o_ctl,
    output l8h_pkg::t_lanes   o_lanes
);
    import l8h_pkg::*;

    t_mix_ctl r_ctl   [MIX_ROWS+1];
    t_lanes   r_lanes [MIX_ROWS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MIX_ROWS; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= i_ctl;
            for (int k = 0; k < MIX_ROWS; k++) begin
                r_ctl[k+1] <= r_ctl[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes[0] <= i_lanes;
            for (int k = 0; k < MIX_ROWS; k++) begin
                r_lanes[k+1] <= mix_row(r_lanes[k], ROW_W'(k));
            end
        end
    end

    assign o_ctl   = r_ctl[MIX_ROWS];
    assign o_lanes = r_lanes[MIX_ROWS];

endmodule

FILE: src/lookup8_hash64_stream.sv
// Top level of the 64-bit lookup8 hash over a byte stream: byte packing, lane state, control.
// Depends on l8h_pkg and l8h_mix_pipe.
// A request with last set enters the mix pipeline for its closing mix when accepted, or waits for
// a block mix of its message to leave the pipeline, when one is in flight or its own byte completes a block.
// Throughput: one request per cycle, stalled while a closing mix waits or the exit is blocked.
// Reset (synchronous, active low): seed returns to 0xABCDEF0011223344, no message open.
module lookup8_hash64_stream (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  l8h_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output l8h_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [63:0]        i_cfg_seed
);
    import l8h_pkg::*;

    // Seed register, used only when a message opens.
    logic [LANE_W-1:0] r_seed;

    // Message state. Lanes hold the running a/b/c: the seed values, then the result of each block mix.
    logic                               r_open;
    logic                               r_busy;   // a block mix of the current message is in flight
    logic                               r_chain;  // a closing mix waits on the in-flight block
    t_lanes                             r_lane;
    logic [BLOCK_BYTES-1:0][7:0]        r_pend;
    logic [POS_W-1:0]                   r_pos;
    logic [LEN_W-1:0]                   r_len;

    // Tail words and length saved for a closing mix that has to wait.
    t_lanes                             r_hold;
    logic [LEN_W-1:0]                   r_hold_len;

    // Output register.
    logic                               r_out_valid;
    t_out_item                          r_out;

    logic                               n_open;
    logic                               n_busy;
    logic                               n_chain;
    t_lanes                             n_lane;
    logic [BLOCK_BYTES-1:0][7:0]        n_pend;
    logic [POS_W-1:0]                   n_pos;
    logic [LEN_W-1:0]                   n_len;
    t_lanes                             n_hold;
    logic [LEN_W-1:0]                   n_hold_len;

    logic                               en;
    logic                               accept;
    logic                               take;
    logic                               full;
    logic                               exit_blk;
    logic                               exit_fin;
    logic                               busy_eff;
    t_lanes                             lanes_cur;
    t_lanes                             base;
    logic [BLOCK_BYTES-1:0][7:0]        pend_new;
    logic [LEN_W-1:0]                   len_new;
    logic [LANE_W-1:0]                  pa;
    logic [LANE_W-1:0]                  pb;
    logic [LANE_W-1:0]                  pc;

    t_mix_ctl                           head_ctl;
    t_lanes                             head_lanes;
    t_mix_ctl                           mix_ctl;
    t_lanes                             mix_lanes;

    // The whole pipeline advances unless a finished hash sits at its exit and the
    // output register cannot take it.
    assign en = !(mix_ctl.valid && mix_ctl.fin && r_out_valid && !i_out_ready);

    // While a chained closing mix is pending, the pipeline entry is reserved for it.
    assign o_in_ready  = en && !r_chain;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    // Idle requests (no byte, no last) leave everything untouched.
    assign take     = accept && (i_in.byte_valid || i_in.last);
    assign full     = i_in.byte_valid && (r_pos == POS_W'(BLOCK_BYTES - 1));

    assign exit_blk = en && mix_ctl.valid && !mix_ctl.fin;
    assign exit_fin = en && mix_ctl.valid && mix_ctl.fin;

    // A block leaving the pipeline this cycle is forwarded, so a request in the same
    // cycle sees the mixed lanes and no longer waits on it.
    assign lanes_cur = exit_blk ? mix_lanes : r_lane;
    assign busy_eff  = r_busy && !exit_blk;

    always_comb begin
        if (r_open) begin
            base = lanes_cur;
        end else begin
            base.a = r_seed;
            base.b = r_seed;
            base.c = GOLDEN64;
        end
    end

    // Drop the new byte into its slot of the 24-byte block.
    always_comb begin
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (i_in.byte_valid && (r_pos == POS_W'(i))) begin
                pend_new[i] = i_in.data_byte;
            end else begin
                pend_new[i] = r_pend[i];
            end
        end
    end

    assign len_new = r_len + LEN_W'(i_in.byte_valid);
    assign pa      = pend_new[WORD_BYTES-1:0];
    assign pb      = pend_new[2*WORD_BYTES-1:WORD_BYTES];
    assign pc      = pend_new[3*WORD_BYTES-1:2*WORD_BYTES];

    // Pipeline entry: a chained closing mix, a full block, a closing mix, or a bubble.
    always_comb begin
        head_ctl   = '0;
        head_lanes = base;
        if (r_chain && exit_blk) begin
            head_ctl.valid = 1'b1;
            head_ctl.fin   = 1'b1;
            head_lanes.a   = mix_lanes.a + r_hold.a;
            head_lanes.b   = mix_lanes.b + r_hold.b;
            head_lanes.c   = mix_lanes.c + LANE_W'(r_hold_len) + (r_hold.c << 8);
        end else if (take && full) begin
            head_ctl.valid = 1'b1;
            head_lanes.a   = base.a + pa;
            head_lanes.b   = base.b + pb;
            head_lanes.c   = base.c + pc;
        end else if (take && i_in.last && !busy_eff) begin
            head_ctl.valid = 1'b1;
            head_ctl.fin   = 1'b1;
            head_lanes.a   = base.a + pa;
            head_lanes.b   = base.b + pb;
            // The tail's third word enters c one byte up, and the length is added to c.
            head_lanes.c   = base.c + LANE_W'(len_new) + (pc << 8);
        end
    end

    always_comb begin
        n_open     = r_open;
        n_busy     = r_busy;
        n_chain    = r_chain;
        n_lane     = r_lane;
        n_pend     = r_pend;
        n_pos      = r_pos;
        n_len      = r_len;
        n_hold     = r_hold;
        n_hold_len = r_hold_len;

        if (exit_blk) begin
            n_busy  = 1'b0;
            n_chain = 1'b0;
            n_lane  = mix_lanes;
        end

        if (take) begin
            if (i_in.last) begin
                // The message closes here; the hash comes out of the pipeline later.
                n_open = 1'b0;
                n_pend = '0;
                n_pos  = '0;
                n_len  = '0;
                if (full || busy_eff) begin
                    // The closing mix needs a block result that is not ready yet. When the
                    // last byte itself completes a block, the tail is empty.
                    n_chain    = 1'b1;
                    n_hold_len = len_new;
                    if (full) begin
                        n_busy = 1'b1;
                        n_hold = '0;
                    end else begin
                        n_hold.a = pa;
                        n_hold.b = pb;
                        n_hold.c = pc;
                    end
                end
            end else begin
                n_open = 1'b1;
                n_len  = len_new;
                if (full) begin
                    n_busy = 1'b1;
                    n_pend = '0;
                    n_pos  = '0;
                end else begin
                    n_lane = base;
                    n_pend = pend_new;
                    n_pos  = r_pos + POS_W'(i_in.byte_valid);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= SEED_RESET;
            r_open  <= 1'b0;
            r_busy  <= 1'b0;
            r_chain <= 1'b0;
            r_pend  <= '0;
            r_pos   <= '0;
            r_len   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed;
            end
            r_open  <= n_open;
            r_busy  <= n_busy;
            r_chain <= n_chain;
            r_pend  <= n_pend;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane     <= n_lane;
        r_hold     <= n_hold;
        r_hold_len <= n_hold_len;
    end

    // The output register takes a finished hash even while the previous one is being
    // taken, so a result every cycle is possible.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exit_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exit_fin) begin
            r_out.hash  <= mix_lanes.c;
            r_out.key32 <= mix_lanes.c[KEY_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    l8h_mix_pipe u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (head_ctl),
        .i_lanes (head_lanes),
        .o_ctl   (mix_ctl),
        .o_lanes (mix_lanes)
    );

endmodule

FILE: verif/tb_lookup8_hash64_stream.sv
// Self-checking testbench for lookup8_hash64_stream, the 64-bit lookup8 hash over a byte stream.
// Depends on l8h_pkg for the request, result and constant definitions, and on the block itself.
// A directed table runs first, then random messages under several seeds; a predictor checks all.
module tb_lookup8_hash64_stream;

    import l8h_pkg::*;

    // With no accepted handshake for this many cycles the run is declared hung.
    localparam int HANG_LIMIT     = 2000;
    // A closing mix may wait behind a block mix; the settling time allows for both.
    localparam int SETTLE_CYCLES  = 30;
    localparam int PHASES         = 6;
    localparam int BYTES_PER_PHASE = 250;

    // Directed requests, sent under the reset seed. Each row's result comes from the predictor.
    localparam int DIRECTED_ROWS = 16;
    localparam t_in_item DIRECTED [DIRECTED_ROWS] = '{
        {8'h00, 1'b0, 1'b0},    // idle request before any message opens
        {8'h3C, 1'b0, 1'b1},    // empty message: closing request without a byte
        {8'hFF, 1'b1, 1'b1},    // one all-ones byte that also closes the message
        {8'h00, 1'b1, 1'b1},    // one zero byte that also closes the message
        {8'hA5, 1'b1, 1'b0},    // two bytes, an idle request between them
        {8'hC3, 1'b0, 1'b0},
        {8'h5A, 1'b1, 1'b0},
        {8'h00, 1'b0, 1'b1},    // empty closing request ends a two-byte message
        {8'h01, 1'b1, 1'b0},    // single set bits, then single clear bits, at both ends of the byte
        {8'h80, 1'b1, 1'b0},
        {8'h7F, 1'b1, 1'b0},
        {8'hFE, 1'b1, 1'b1},
        {8'h00, 1'b0, 1'b1},    // two empty messages back to back
        {8'hFF, 1'b0, 1'b1},
        {8'h00, 1'b0, 1'b0},    // trailing idle requests change nothing
        {8'hFF, 1'b0, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [63:0] i_cfg_seed;

    lookup8_hash64_stream DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Predictor state: the seed shadow, the three lanes, the partial block and the length.
    logic [63:0] seed_shadow;
    logic [63:0] lane_a, lane_b, lane_c;
    logic [63:0] word_a, word_b, word_c;
    logic [4:0]  fill;
    logic [31:0] msg_len;
    bit          msg_open;
    t_out_item   expected_hashes [$];

    int  errors       = 0;
    int  quiet_cycles = 0;
    int  bytes_sent   = 0;
    int  ready_hold   = 0;
    // When clear, neither the sender nor the receiver inserts idle cycles.
    bit  idling       = 1'b1;

    // The 12-row subtract / xor-shift ladder applied to the predictor's lanes.
    function automatic void scramble_lanes();
        lane_a = lane_a - lane_b - lane_c;  lane_a = lane_a ^ (lane_c >> 43);
        lane_b = lane_b - lane_c - lane_a;  lane_b = lane_b ^ (lane_a << 9);
        lane_c = lane_c - lane_a - lane_b;  lane_c = lane_c ^ (lane_b >> 8);
        lane_a = lane_a - lane_b - lane_c;  lane_a = lane_a ^ (lane_c >> 38);
        lane_b = lane_b - lane_c - lane_a;  lane_b = lane_b ^ (lane_a << 23);
        lane_c = lane_c - lane_a - lane_b;  lane_c = lane_c ^ (lane_b >> 5);
        lane_a = lane_a - lane_b - lane_c;  lane_a = lane_a ^ (lane_c >> 35);
        lane_b = lane_b - lane_c - lane_a;  lane_b = lane_b ^ (lane_a << 49);
        lane_c = lane_c - lane_a - lane_b;  lane_c = lane_c ^ (lane_b >> 11);
        lane_a = lane_a - lane_b - lane_c;  lane_a = lane_a ^ (lane_c >> 12);
        lane_b = lane_b - lane_c - lane_a;  lane_b = lane_b ^ (lane_a << 18);
        lane_c = lane_c - lane_a - lane_b;  lane_c = lane_c ^ (lane_b >> 22);
    endfunction

    function automatic void clear_block();
        word_a = '0;
        word_b = '0;
        word_c = '0;
        fill   = '0;
    endfunction

    // Folds one accepted request into the predicted state and queues the hash it closes, if any.
    function automatic void absorb_request(input t_in_item r);
        logic [63:0] placed;
        t_out_item   res;
        if (!r.byte_valid && !r.last)
            return;
        // The first byte or closing request of a message loads the lanes from the seed.
        if (!msg_open) begin
            lane_a   = seed_shadow;
            lane_b   = seed_shadow;
            lane_c   = GOLDEN64;
            clear_block();
            msg_len  = '0;
            msg_open = 1'b1;
        end
        if (r.byte_valid) begin
            placed = {56'd0, r.data_byte} << {fill[2:0], 3'b000};
            if (fill < 8)
                word_a = word_a | placed;
            else if (fill < 16)
                word_b = word_b | placed;
            else
                word_c = word_c | placed;
            msg_len = msg_len + 32'd1;
            fill    = fill + 5'd1;
            // A full 24-byte block is added in and mixed at once, even on the closing byte.
            if (fill == 5'd24) begin
                lane_a = lane_a + word_a;
                lane_b = lane_b + word_b;
                lane_c = lane_c + word_c;
                scramble_lanes();
                clear_block();
            end
        end
        if (!r.last)
            return;
        // Closing: length into c, then the partial block with its c bytes one byte up.
        lane_c = lane_c + {32'd0, msg_len};
        lane_a = lane_a + word_a;
        lane_b = lane_b + word_b;
        lane_c = lane_c + (word_c << 8);
        scramble_lanes();
        res.hash  = lane_c;
        res.key32 = lane_c[31:0];
        expected_hashes.push_back(res);
        clear_block();
        msg_len  = '0;
        msg_open = 1'b0;
    endfunction

    function automatic t_in_item mk_req(input logic [7:0] b, input logic v, input logic l);
        t_in_item r;
        r.data_byte  = b;
        r.byte_valid = v;
        r.last       = l;
        return r;
    endfunction

    // Everything is observed at the rising edge: handshakes feed the predictor and the checker.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            seed_shadow = SEED_RESET;
            lane_a      = SEED_RESET;
            lane_b      = SEED_RESET;
            lane_c      = GOLDEN64;
            clear_block();
            msg_len     = '0;
            msg_open    = 1'b0;
            expected_hashes.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hashes.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, hash %h key32 %h",
                             $time, o_out.hash, o_out.key32);
                end else begin
                    want = expected_hashes.pop_front();
                    if (o_out.hash !== want.hash) begin
                        errors++;
                        $display("%0t: hash mismatch, expected %h actual %h",
                                 $time, want.hash, o_out.hash);
                    end
                    if (o_out.key32 !== want.key32) begin
                        errors++;
                        $display("%0t: key32 mismatch, expected %h actual %h",
                                 $time, want.key32, o_out.key32);
                    end
                end
            end
            if (i_in_valid && o_in_ready)
                absorb_request(i_in);
            if (i_cfg_valid && o_cfg_ready)
                seed_shadow = i_cfg_seed;
        end

        // Watchdog: any accepted handshake restarts the count of silent cycles.
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, HANG_LIMIT, expected_hashes.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: ready drops in random bursts while idling is on.
    always @(negedge i_clk) begin
        if (idling && ready_hold == 0 && $urandom_range(0, 7) == 0)
            ready_hold = $urandom_range(1, 4);
        if (ready_hold != 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Presents one request at a falling edge, perhaps after a short gap, and returns at the
    // falling edge after it was accepted with valid still high.
    task automatic send_request(input t_in_item r);
        int gap;
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One well-formed message of random bytes, sometimes with idle requests mixed in. It closes
    // either on its last byte or with a separate empty closing request.
    task automatic send_message(input int len, input bit close_empty);
        int k;
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0)
                send_request(mk_req(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            send_request(mk_req(8'($urandom_range(0, 255)), 1'b1,
                                (k == len - 1) && !close_empty));
            bytes_sent++;
        end
        if (close_empty || len == 0) begin
            send_request(mk_req(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            bytes_sent++;
        end
    endtask

    // Stops the sender until every predicted hash has come out, then lets a block mix that
    // produces no result run through before anything else happens.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (expected_hashes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_seed(input logic [63:0] value);
        i_cfg_seed  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int          row;
        int          phase;
        int          len;
        logic [63:0] seed_value;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_seed  = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part runs under the seed left by reset.
        for (row = 0; row < DIRECTED_ROWS; row++)
            send_request(DIRECTED[row]);
        drain_block();

        // Random part: each phase runs under its own seed, zero and all ones among them.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       seed_value = 64'd0;
                1:       seed_value = '1;
                4:       seed_value = SEED_RESET;
                default: seed_value = {$urandom(), $urandom()};
            endcase
            load_seed(seed_value);
            bytes_sent = 0;
            while (bytes_sent < BYTES_PER_PHASE) begin
                // Each message is gappy or back-to-back at random; the final phase has no gaps.
                idling = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
                // Lengths favor the block edges: empty, one short of a block, whole blocks.
                case ($urandom_range(0, 9))
                    0:       len = 0;
                    1:       len = 23;
                    2:       len = 24;
                    3:       len = 48;
                    4:       len = $urandom_range(49, 120);
                    5:       len = $urandom_range(25, 47);
                    default: len = $urandom_range(1, 22);
                endcase
                send_message(len, $urandom_range(0, 3) == 0);
            end
            drain_block();
        end

        errors += expected_hashes.size();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
src/l8h_pkg.sv
src/l8h_mix_pipe.sv
src/lookup8_hash64_stream.sv
verif/tb_lookup8_hash64_stream.sv
